/* hw/rtl/erm_pkg.sv */
// shared types, constants and tables for the euler rotation matrix block
`default_nettype none

package erm_pkg;

	// field widths
	localparam int ANG_W = 16;
	localparam int OUT_W = 16;

	// angle units: 1/64 degree
	localparam int FULL_TURN    = 23040;
	localparam int QUARTER_TURN = 5760;

	// remainder split r = 45*u + w, with 5760 = 128*45
	localparam int R_W         = 13;
	localparam int U_W         = 8;
	localparam int W_W         = 6;
	localparam int QDIV        = 45;
	localparam int RECIP_W     = 11;
	localparam int RECIP_45    = 1457;
	localparam int RECIP_SHIFT = 16;
	localparam int ZFRAC_W     = 23;
	localparam int ZBIAS       = 22;
	localparam int ZTAB_LEN    = 64;

	// cordic datapath
	localparam int CW        = 33;
	localparam int PW        = 32;
	localparam int SW        = PW + 2;
	localparam int TABLE_LEN = 24;
	localparam int GAIN_Q30  = 652032874;
	localparam int Q_FRAC    = 30;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int OUT_FRAC_BITS     = 14;

	// quadrant codes
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic [1:0]           quad;
	} cordic_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] c0r0;
		logic signed [OUT_W-1:0] c0r1;
		logic signed [OUT_W-1:0] c0r2;
		logic signed [OUT_W-1:0] c1r0;
		logic signed [OUT_W-1:0] c1r1;
		logic signed [OUT_W-1:0] c1r2;
		logic signed [OUT_W-1:0] c2r0;
		logic signed [OUT_W-1:0] c2r1;
		logic signed [OUT_W-1:0] c2r2;
	} mat_t;

	typedef logic [ZFRAC_W-1:0] ztab_t [ZTAB_LEN];

	// floor((w*2^23 + 22) / 45), the low part of the binary angle
	function automatic ztab_t ztab_build();
		ztab_t t;
		for (int i = 0; i < ZTAB_LEN; i++) begin
			t[i] = ZFRAC_W'((longint'(i) * (longint'(1) << ZFRAC_W) + ZBIAS) / QDIV);
		end
		return t;
	endfunction

	localparam ztab_t ZTAB = ztab_build();

	// atan(2^-i) on a scale where 2^32 is a full turn
	function automatic logic signed [CW-1:0] atan_q32(input int i);
		int v;
		case (i)
			0:  v = 536870912;
			1:  v = 316933406;
			2:  v = 167458907;
			3:  v = 85004756;
			4:  v = 42667331;
			5:  v = 21354465;
			6:  v = 10679838;
			7:  v = 5340245;
			8:  v = 2670163;
			9:  v = 1335087;
			10: v = 667544;
			11: v = 333772;
			12: v = 166886;
			13: v = 83443;
			14: v = 41722;
			15: v = 20861;
			16: v = 10430;
			17: v = 5215;
			18: v = 2608;
			19: v = 1304;
			20: v = 652;
			21: v = 326;
			22: v = 163;
			23: v = 81;
			default: v = 0;
		endcase
		return CW'(v);
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/erm_angle_prep.sv */
// angle reduction to quadrant and binary angle, five register stages
`default_nettype none

module erm_angle_prep (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [erm_pkg::ANG_W-1:0]  angle,
	output logic signed [erm_pkg::CW-1:0]          z,
	output logic [1:0]                             quad
);

	localparam logic signed [erm_pkg::ANG_W:0] FT = (erm_pkg::ANG_W+1)'(erm_pkg::FULL_TURN);
	localparam logic signed [erm_pkg::ANG_W:0] FT2 =
		(erm_pkg::ANG_W+1)'(2 * erm_pkg::FULL_TURN);
	localparam logic [14:0] A_Q1 = 15'(erm_pkg::QUARTER_TURN);
	localparam logic [14:0] A_Q2 = 15'(2 * erm_pkg::QUARTER_TURN);
	localparam logic [14:0] A_Q3 = 15'(3 * erm_pkg::QUARTER_TURN);
	localparam int PR_W = erm_pkg::R_W + erm_pkg::RECIP_W;
	localparam int M_W  = erm_pkg::U_W + erm_pkg::W_W;

	logic signed [erm_pkg::ANG_W:0] v;
	logic signed [erm_pkg::ANG_W:0] a_c;
	logic [14:0]                    a_s1;
	logic [1:0]                     q_c;
	logic [erm_pkg::R_W-1:0]        r_c;
	logic [1:0]                     q_s2;
	logic [erm_pkg::R_W-1:0]        r_s2;
	logic [PR_W-1:0]                rp;
	logic [erm_pkg::U_W-1:0]        u1_s3;
	logic [erm_pkg::R_W-1:0]        r_s3;
	logic [1:0]                     q_s3;
	logic [M_W-1:0]                 m45;
	logic signed [M_W:0]            wd;
	logic [erm_pkg::U_W-2:0]        u_c;
	logic [erm_pkg::W_W-1:0]        w_c;
	logic [erm_pkg::U_W-2:0]        u_s4;
	logic [erm_pkg::W_W-1:0]        w_s4;
	logic [1:0]                     q_s4;

	// modulo a full turn, the adds run in parallel
	assign v = (erm_pkg::ANG_W+1)'(angle);
	always_comb begin
		priority if (v >= FT) begin
			a_c = v - FT;
		end else if (v >= 0) begin
			a_c = v;
		end else if (v >= -FT) begin
			a_c = v + FT;
		end else begin
			a_c = v + FT2;
		end
	end

	// quadrant and remainder
	always_comb begin
		priority if (a_s1 >= A_Q3) begin
			q_c = erm_pkg::QUAD_3;
			r_c = erm_pkg::R_W'(a_s1 - A_Q3);
		end else if (a_s1 >= A_Q2) begin
			q_c = erm_pkg::QUAD_2;
			r_c = erm_pkg::R_W'(a_s1 - A_Q2);
		end else if (a_s1 >= A_Q1) begin
			q_c = erm_pkg::QUAD_1;
			r_c = erm_pkg::R_W'(a_s1 - A_Q1);
		end else begin
			q_c = erm_pkg::QUAD_0;
			r_c = erm_pkg::R_W'(a_s1);
		end
	end

	// u estimate by reciprocal, at most one too large
	assign rp = PR_W'(r_s2) * PR_W'(erm_pkg::RECIP_45);

	// remainder against 45, fix the estimate
	assign m45 = M_W'(u1_s3) * M_W'(erm_pkg::QDIV);
	assign wd  = $signed({2'b00, r_s3}) - $signed({1'b0, m45});
	always_comb begin
		if (wd < 0) begin
			u_c = (erm_pkg::U_W-1)'(u1_s3 - erm_pkg::U_W'(1));
			w_c = erm_pkg::W_W'(wd + (M_W+1)'(erm_pkg::QDIV));
		end else begin
			u_c = u1_s3[erm_pkg::U_W-2:0];
			w_c = wd[erm_pkg::W_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= a_c[14:0];
			q_s2  <= q_c;
			r_s2  <= r_c;
			u1_s3 <= rp[erm_pkg::RECIP_SHIFT +: erm_pkg::U_W];
			r_s3  <= r_s2;
			q_s3  <= q_s2;
			u_s4  <= u_c;
			w_s4  <= w_c;
			q_s4  <= q_s3;
			z     <= erm_pkg::CW'({u_s4, erm_pkg::ZTAB[w_s4]});
			quad  <= q_s4;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/erm_cordic_cell.sv */
// one cordic rotation step with its output register
`default_nettype none

module erm_cordic_cell #(
	parameter int IDX = 0
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire erm_pkg::cordic_t d_i,
	output erm_pkg::cordic_t      d_o
);

	localparam logic signed [erm_pkg::CW-1:0] ATAN = erm_pkg::atan_q32(IDX);

	logic signed [erm_pkg::CW-1:0] xi;
	logic signed [erm_pkg::CW-1:0] yi;
	logic signed [erm_pkg::CW-1:0] zi;
	logic signed [erm_pkg::CW-1:0] sh_x;
	logic signed [erm_pkg::CW-1:0] sh_y;
	erm_pkg::cordic_t              nxt;

	assign xi   = d_i.x;
	assign yi   = d_i.y;
	assign zi   = d_i.z;
	assign sh_x = xi >>> IDX;
	assign sh_y = yi >>> IDX;

	always_comb begin
		nxt.quad = d_i.quad;
		if (!zi[erm_pkg::CW-1]) begin
			nxt.x = xi - sh_y;
			nxt.y = yi + sh_x;
			nxt.z = zi - ATAN;
		end else begin
			nxt.x = xi + sh_y;
			nxt.y = yi - sh_x;
			nxt.z = zi + ATAN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_o <= nxt;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/erm_matrix_mult.sv */
// quadrant fold, products, sums and output rounding, five register stages
`default_nettype none

module erm_matrix_mult (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire erm_pkg::cordic_t lane_x,
	input  wire erm_pkg::cordic_t lane_y,
	input  wire erm_pkg::cordic_t lane_z,
	output erm_pkg::mat_t         mat
);

	localparam int PW     = erm_pkg::PW;
	localparam int SW     = erm_pkg::SW;
	localparam int FB     = erm_pkg::OUT_FRAC_BITS > erm_pkg::Q_FRAC ?
		erm_pkg::Q_FRAC : erm_pkg::OUT_FRAC_BITS;
	localparam int RND_SH = erm_pkg::Q_FRAC - FB;
	localparam logic signed [SW:0] HALF = ((SW+1)'(1) << RND_SH) >>> 1;
	localparam logic signed [SW:0] ONE  = (SW+1)'(1) << FB;

	// q30 product, floor shift
	function automatic logic signed [PW-1:0] mulq(input logic signed [PW-1:0] a,
		input logic signed [PW-1:0] b);
		logic signed [2*PW-1:0] p;
		p = a * b;
		return p[erm_pkg::Q_FRAC +: PW];
	endfunction

	function automatic logic signed [erm_pkg::OUT_W-1:0] rnd_sat(
		input logic signed [SW-1:0] v);
		logic signed [SW:0] t;
		t = (SW+1)'(v) + HALF;
		t = t >>> RND_SH;
		if (t > ONE) begin
			t = ONE;
		end else if (t < -ONE) begin
			t = -ONE;
		end
		return t[erm_pkg::OUT_W-1:0];
	endfunction

	function automatic logic signed [2*PW-1:0] fold(input erm_pkg::cordic_t d);
		logic signed [PW-1:0] c;
		logic signed [PW-1:0] s;
		unique case (d.quad)
			erm_pkg::QUAD_0: begin
				c = PW'(d.x);
				s = PW'(d.y);
			end
			erm_pkg::QUAD_1: begin
				c = PW'(-d.y);
				s = PW'(d.x);
			end
			erm_pkg::QUAD_2: begin
				c = PW'(-d.x);
				s = PW'(-d.y);
			end
			default: begin
				c = PW'(d.y);
				s = PW'(-d.x);
			end
		endcase
		return {c, s};
	endfunction

	logic signed [PW-1:0] cx_s1, sx_s1, cy_s1, sy_s1, cz_s1, sz_s1;

	logic signed [PW-1:0] czcy_s2, szcy_s2, szcx_s2, czcx_s2, cysx_s2;
	logic signed [PW-1:0] szsx_s2, czsx_s2, cycx_s2, czsy_s2, szsy_s2;
	logic signed [PW-1:0] sy_s2, cx_s2, sx_s2;

	logic signed [PW-1:0] czcy_s3, szcy_s3, szcx_s3, czcx_s3, cysx_s3;
	logic signed [PW-1:0] szsx_s3, czsx_s3, cycx_s3, sy_s3;
	logic signed [PW-1:0] czsysx_s3, szsysx_s3, czsycx_s3, szsycx_s3;

	logic signed [SW-1:0] e_s4 [9];

	always_ff @(posedge clk) begin
		if (en) begin
			{cx_s1, sx_s1} <= fold(lane_x);
			{cy_s1, sy_s1} <= fold(lane_y);
			{cz_s1, sz_s1} <= fold(lane_z);

			czcy_s2 <= mulq(cz_s1, cy_s1);
			szcy_s2 <= mulq(sz_s1, cy_s1);
			szcx_s2 <= mulq(sz_s1, cx_s1);
			czcx_s2 <= mulq(cz_s1, cx_s1);
			cysx_s2 <= mulq(cy_s1, sx_s1);
			szsx_s2 <= mulq(sz_s1, sx_s1);
			czsx_s2 <= mulq(cz_s1, sx_s1);
			cycx_s2 <= mulq(cy_s1, cx_s1);
			czsy_s2 <= mulq(cz_s1, sy_s1);
			szsy_s2 <= mulq(sz_s1, sy_s1);
			sy_s2   <= sy_s1;
			cx_s2   <= cx_s1;
			sx_s2   <= sx_s1;

			// second factor of the triple products
			czsysx_s3 <= mulq(czsy_s2, sx_s2);
			szsysx_s3 <= mulq(szsy_s2, sx_s2);
			czsycx_s3 <= mulq(czsy_s2, cx_s2);
			szsycx_s3 <= mulq(szsy_s2, cx_s2);
			czcy_s3   <= czcy_s2;
			szcy_s3   <= szcy_s2;
			szcx_s3   <= szcx_s2;
			czcx_s3   <= czcx_s2;
			cysx_s3   <= cysx_s2;
			szsx_s3   <= szsx_s2;
			czsx_s3   <= czsx_s2;
			cycx_s3   <= cycx_s2;
			sy_s3     <= sy_s2;

			e_s4[0] <= SW'(czcy_s3);
			e_s4[1] <= -SW'(szcy_s3);
			e_s4[2] <= SW'(sy_s3);
			e_s4[3] <= SW'(szcx_s3) + SW'(czsysx_s3);
			e_s4[4] <= SW'(czcx_s3) - SW'(szsysx_s3);
			e_s4[5] <= -SW'(cysx_s3);
			e_s4[6] <= SW'(szsx_s3) - SW'(czsycx_s3);
			e_s4[7] <= SW'(czsx_s3) + SW'(szsycx_s3);
			e_s4[8] <= SW'(cycx_s3);

			mat.c0r0 <= rnd_sat(e_s4[0]);
			mat.c0r1 <= rnd_sat(e_s4[1]);
			mat.c0r2 <= rnd_sat(e_s4[2]);
			mat.c1r0 <= rnd_sat(e_s4[3]);
			mat.c1r1 <= rnd_sat(e_s4[4]);
			mat.c1r2 <= rnd_sat(e_s4[5]);
			mat.c2r0 <= rnd_sat(e_s4[6]);
			mat.c2r1 <= rnd_sat(e_s4[7]);
			mat.c2r2 <= rnd_sat(e_s4[8]);
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/euler_rotation_matrix.sv */
// euler angles (x-y-z) to 3x3 rotation matrix Rz*Ry*Rx, pipelined cordic
//
//  channel  handshake             payload
//  -------  --------------------  -----------------------------------------
//  in       in_valid / in_ready   angle_x, angle_y, angle_z  (s16, 1/64 deg)
//  out      out_valid / out_ready col0_row0 .. col2_row2     (s16, q2.14)
//
// one transfer per cycle in each direction while the skid register is empty;
// from input transfer to output valid a result passes 5 angle reduction
// stages, one cordic cell per stage, 5 fold/multiply/round, 1 output register
// the pipeline advances as one, held only while the skid register is full
// an output register plus a one-entry skid register sit at the end, so a
// stalled result does not block the next input transfer
// arst_n clears the stage valid bits and the output/skid valid flags only
`default_nettype none

module euler_rotation_matrix #(
	parameter int CORDIC_STAGES = erm_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [erm_pkg::ANG_W-1:0]  angle_x,
	input  wire logic signed [erm_pkg::ANG_W-1:0]  angle_y,
	input  wire logic signed [erm_pkg::ANG_W-1:0]  angle_z,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [erm_pkg::OUT_W-1:0]       col0_row0,
	output logic signed [erm_pkg::OUT_W-1:0]       col0_row1,
	output logic signed [erm_pkg::OUT_W-1:0]       col0_row2,
	output logic signed [erm_pkg::OUT_W-1:0]       col1_row0,
	output logic signed [erm_pkg::OUT_W-1:0]       col1_row1,
	output logic signed [erm_pkg::OUT_W-1:0]       col1_row2,
	output logic signed [erm_pkg::OUT_W-1:0]       col2_row0,
	output logic signed [erm_pkg::OUT_W-1:0]       col2_row1,
	output logic signed [erm_pkg::OUT_W-1:0]       col2_row2
);

	// stage counts above the atan table length act as the table length
	localparam int NSTAGE = CORDIC_STAGES > erm_pkg::TABLE_LEN ?
		erm_pkg::TABLE_LEN : CORDIC_STAGES;
	localparam int PREP_LAT = 5;
	localparam int MULT_LAT = 5;
	localparam int LAT      = PREP_LAT + NSTAGE + MULT_LAT;

	logic                                en;
	logic [LAT-1:0]                      vld_q;
	logic signed [erm_pkg::ANG_W-1:0]    ang [3];
	logic signed [erm_pkg::CW-1:0]       pz [3];
	logic [1:0]                          pq [3];
	erm_pkg::cordic_t                    cd [3][NSTAGE+1];
	erm_pkg::mat_t                       mat;

	logic          out_v_q;
	logic          skid_v_q;
	erm_pkg::mat_t out_q;
	erm_pkg::mat_t skid_q;
	logic          arrive;
	logic          take;
	logic          out_free;
	logic          load_out;
	logic          load_skid;

	// whole pipeline moves unless the skid register holds a result
	assign en       = !skid_v_q;
	assign in_ready = en;

	assign ang[0] = angle_x;
	assign ang[1] = angle_y;
	assign ang[2] = angle_z;

	// one lane per angle: reduction, then a row of cordic cells
	for (genvar l = 0; l < 3; l++) begin : g_lane
		erm_angle_prep u_prep (
			.clk   (clk),
			.en    (en),
			.angle (ang[l]),
			.z     (pz[l]),
			.quad  (pq[l])
		);

		// start vector is the cordic gain on the x axis
		assign cd[l][0].x    = erm_pkg::CW'(erm_pkg::GAIN_Q30);
		assign cd[l][0].y    = '0;
		assign cd[l][0].z    = pz[l];
		assign cd[l][0].quad = pq[l];

		for (genvar s = 0; s < NSTAGE; s++) begin : g_cell
			erm_cordic_cell #(
				.IDX (s)
			) u_cell (
				.clk (clk),
				.en  (en),
				.d_i (cd[l][s]),
				.d_o (cd[l][s+1])
			);
		end
	end

	erm_matrix_mult u_mult (
		.clk    (clk),
		.en     (en),
		.lane_x (cd[0][NSTAGE]),
		.lane_y (cd[1][NSTAGE]),
		.lane_z (cd[2][NSTAGE]),
		.mat    (mat)
	);

	// valid bit for each register stage of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// output register and skid register
	assign arrive    = en && vld_q[LAT-1];
	assign take      = out_v_q && out_ready;
	assign out_free  = !out_v_q || take;
	assign load_out  = out_free && (skid_v_q || arrive);
	assign load_skid = !out_free && arrive;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_v_q  <= skid_v_q || arrive;
				skid_v_q <= 1'b0;
			end else if (load_skid) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= skid_v_q ? skid_q : mat;
		end
		if (load_skid) begin
			skid_q <= mat;
		end
	end

	assign out_valid = out_v_q;
	assign col0_row0 = out_q.c0r0;
	assign col0_row1 = out_q.c0r1;
	assign col0_row2 = out_q.c0r2;
	assign col1_row0 = out_q.c1r0;
	assign col1_row1 = out_q.c1r1;
	assign col1_row2 = out_q.c1r2;
	assign col2_row0 = out_q.c2r0;
	assign col2_row1 = out_q.c2r1;
	assign col2_row2 = out_q.c2r2;

	// skid register only fills behind a full output register
	a_skid_needs_out : assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full while output register empty");

	// skid fills only after a stalled output
	a_skid_after_stall : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !out_ready))
		else $error("skid register filled without an output stall");

	// a new result appears only when the last stage held a valid item
	a_out_from_pipe : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(vld_q[LAT-1] && en))
		else $error("output valid without an item leaving the pipeline");

endmodule

`default_nettype wire
